/* rtl/tlpf_pkg.sv */
// ----------------------------------------------------------------------------
// tlpf_pkg
// Types and constants shared by the two-level predicate filter.
// ----------------------------------------------------------------------------
package tlpf_pkg;

    localparam logic [2:0] OP_EQ = 3'd0;
    localparam logic [2:0] OP_GT = 3'd1;
    localparam logic [2:0] OP_GE = 3'd2;
    localparam logic [2:0] OP_LT = 3'd3;
    localparam logic [2:0] OP_LE = 3'd4;
    localparam logic [2:0] OP_NE = 3'd5;

    localparam logic [1:0] LINK_AND = 2'd0;
    localparam logic [1:0] LINK_OR  = 2'd1;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [31:0] threshold_bits;
        logic [2:0]  compare_op;
        logic        term_known;
        logic        term_present;
        logic [1:0]  group_link;
        logic [1:0]  query_link;
        logic        last_in_group;
        logic        last_in_query;
        logic        query_empty;
    } in_item_t;

    typedef struct packed {
        logic verdict;
        logic decided;
    } out_item_t;

endpackage

/* rtl/two_level_predicate_filter_top.sv */
// ----------------------------------------------------------------------------
// two_level_predicate_filter_top
// Streams query terms and emits one verdict per closed query.
// ----------------------------------------------------------------------------
// channel | ports                         | payload
// input   | s_valid, s_ready, s_item      | tlpf_pkg::in_item_t
// result  | m_valid, m_ready, m_item      | tlpf_pkg::out_item_t
//
// one term per cycle; the input register feeds the compare and fold logic,
// which writes the result register, so a verdict is valid after its closing
// term passes both registers. aresetn clears the pipeline and all fold state.
// a stalled result holds the pipeline; s_ready follows the input stage.
// ----------------------------------------------------------------------------
module two_level_predicate_filter_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlpf_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output tlpf_pkg::out_item_t m_item
);

    logic                in_valid_reg;
    tlpf_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg, out_valid_next;
    tlpf_pkg::out_item_t out_item_reg, out_item_next;

    logic gs_reg, go_reg, gk_reg, qs_reg, qo_reg, qk_reg;
    logic gs_next, go_next, gk_next, qs_next, qo_next, qk_next;

    logic holds;
    logic adv;
    logic in_ready;
    logic gs1, go1, gk1;
    logic r_true, r_false, r_und;
    logic qs1, qo1, qk1;

    // stage 2 can take work when result slot is free or draining
    assign adv      = !out_valid_reg || m_ready;
    assign in_ready = !in_valid_reg || adv;
    assign s_ready  = in_ready;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    tlpf_fcmp u_fcmp (
        .value_bits     (in_item_reg.value_bits),
        .threshold_bits (in_item_reg.threshold_bits),
        .compare_op     (in_item_reg.compare_op),
        .holds          (holds)
    );

    always_comb begin
        gs1 = gs_reg; go1 = go_reg; gk1 = gk_reg;
        if (in_item_reg.term_present && !gs_reg) begin
            if (in_item_reg.term_known) begin
                if (in_item_reg.group_link == tlpf_pkg::LINK_AND && !holds) begin
                    gs1 = 1'b1; go1 = 1'b0;
                end else if (in_item_reg.group_link == tlpf_pkg::LINK_OR && holds) begin
                    gs1 = 1'b1; go1 = 1'b1;
                end
            end else begin
                gk1 = 1'b0;
            end
        end
        // group result as false / true / undecided
        r_true  = gs1 ? go1 : (gk1 && in_item_reg.group_link == tlpf_pkg::LINK_AND);
        r_false = gs1 ? !go1 : (gk1 && in_item_reg.group_link != tlpf_pkg::LINK_AND);
        r_und   = !gs1 && !gk1;
        qs1 = qs_reg; qo1 = qo_reg; qk1 = qk_reg;
        if ((in_item_reg.last_in_group || in_item_reg.last_in_query) && !qs_reg) begin
            if (in_item_reg.query_link == tlpf_pkg::LINK_AND && r_false) begin
                qs1 = 1'b1; qo1 = 1'b0;
            end else if (in_item_reg.query_link == tlpf_pkg::LINK_OR && r_true) begin
                qs1 = 1'b1; qo1 = 1'b1;
            end else if (r_und) begin
                qk1 = 1'b0;
            end
        end

        gs_next = gs_reg; go_next = go_reg; gk_next = gk_reg;
        qs_next = qs_reg; qo_next = qo_reg; qk_next = qk_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_item_next  = out_item_reg;
        if (in_valid_reg && adv) begin
            if (in_item_reg.query_empty || in_item_reg.last_in_query) begin
                gs_next = 1'b0; go_next = 1'b0; gk_next = 1'b1;
                qs_next = 1'b0; qo_next = 1'b0; qk_next = 1'b1;
                out_valid_next = 1'b1;
                if (in_item_reg.query_empty) begin
                    out_item_next = '{verdict: 1'b1, decided: 1'b1};
                end else if (qs1) begin
                    out_item_next = '{verdict: qo1, decided: 1'b1};
                end else if (qk1) begin
                    out_item_next = '{verdict: (in_item_reg.query_link == tlpf_pkg::LINK_AND),
                                      decided: 1'b1};
                end else begin
                    out_item_next = '{verdict: 1'b1, decided: 1'b0};
                end
            end else begin
                qs_next = qs1; qo_next = qo1; qk_next = qk1;
                if (in_item_reg.last_in_group) begin
                    gs_next = 1'b0; go_next = 1'b0; gk_next = 1'b1;
                end else begin
                    gs_next = gs1; go_next = go1; gk_next = gk1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            gs_reg <= 1'b0; go_reg <= 1'b0; gk_reg <= 1'b1;
            qs_reg <= 1'b0; qo_reg <= 1'b0; qk_reg <= 1'b1;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
            gs_reg <= gs_next; go_reg <= go_next; gk_reg <= gk_next;
            qs_reg <= qs_next; qo_reg <= qo_next; qk_reg <= qk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        out_item_reg <= out_item_next;
    end

    // a result waiting on a stalled sink must not change
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // an undecided verdict always passes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.decided |-> m_item.verdict)
        else $error("undecided verdict failed");

    // closing a query returns the fold state to reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && adv && in_item_reg.last_in_query |=> !qs_reg && qk_reg && !gs_reg)
        else $error("state not cleared after query close");

endmodule

/* rtl/tlpf_fcmp.sv */
// ----------------------------------------------------------------------------
// tlpf_fcmp
// IEEE single compare of value against threshold for one comparison code.
// ----------------------------------------------------------------------------
module tlpf_fcmp (
    input  logic [31:0] value_bits,
    input  logic [31:0] threshold_bits,
    input  logic [2:0]  compare_op,
    output logic        holds
);

    logic        v_nan;
    logic        t_nan;
    logic [31:0] kv;
    logic [31:0] kt;

    function automatic logic [31:0] order_key(input logic [31:0] b);
        logic [31:0] z;
        z = (b[30:0] == 31'd0) ? 32'd0 : b;
        return z[31] ? ~z : (z | 32'h8000_0000);
    endfunction

    assign v_nan = (value_bits[30:23] == 8'hff) && (value_bits[22:0] != 23'd0);
    assign t_nan = (threshold_bits[30:23] == 8'hff) && (threshold_bits[22:0] != 23'd0);
    assign kv    = order_key(value_bits);
    assign kt    = order_key(threshold_bits);

    always_comb begin
        if (v_nan || t_nan) begin
            holds = (compare_op == tlpf_pkg::OP_NE);
        end else begin
            unique case (compare_op)
                tlpf_pkg::OP_EQ: holds = (kv == kt);
                tlpf_pkg::OP_GT: holds = (kv > kt);
                tlpf_pkg::OP_GE: holds = (kv >= kt);
                tlpf_pkg::OP_LT: holds = (kv < kt);
                tlpf_pkg::OP_LE: holds = (kv <= kt);
                tlpf_pkg::OP_NE: holds = (kv != kt);
                default:         holds = 1'b0;
            endcase
        end
    end

endmodule
